// File: rtl/i2p_pkg.sv
package i2p_pkg;

	// operator codes as held on the stack
	typedef enum logic [2:0] {
		OP_LPAREN = 3'd0,
		OP_ADD    = 3'd1,
		OP_SUB    = 3'd2,
		OP_MUL    = 3'd3,
		OP_DIV    = 3'd4,
		OP_POW    = 3'd5
	} op_code_t;

	// character classes of an input item
	typedef enum logic [2:0] {
		CLS_OPERAND,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OPER,
		CLS_OTHER
	} char_cls_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_OP,
		ST_POP_CLOSE,
		ST_FLUSH,
		ST_BARE
	} state_t;

	// ascii characters
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_MUL     = 8'h2A;
	localparam logic [7:0] CH_ADD     = 8'h2B;
	localparam logic [7:0] CH_SUB     = 8'h2D;
	localparam logic [7:0] CH_DIV     = 8'h2F;
	localparam logic [7:0] CH_POW     = 8'h5E;
	localparam logic [7:0] CH_DIGIT_0 = 8'd48;
	localparam logic [7:0] CH_DIGIT_9 = 8'd57;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;
	localparam logic [7:0] CH_NONE    = 8'd0;

	// stack command from the sequencer
	typedef struct packed {
		logic     push;
		logic     pop;
		op_code_t code;
	} stk_cmd_t;

	// stack status towards the sequencer
	typedef struct packed {
		logic     empty;
		logic     full;
		logic     ops_zero;
		logic     ops_one;
		logic     paren_zero;
		op_code_t top;
	} stk_stat_t;

	// one result item from the sequencer
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       has_char;
		logic       last;
	} emit_t;

	function automatic char_cls_t classify(logic [7:0] c);
		char_cls_t cls;
		if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
			(c >= CH_DIGIT_0 && c <= CH_DIGIT_9)) begin
			cls = CLS_OPERAND;
		end else if (c == CH_LPAREN) begin
			cls = CLS_OPEN;
		end else if (c == CH_RPAREN) begin
			cls = CLS_CLOSE;
		end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV ||
			c == CH_POW) begin
			cls = CLS_OPER;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction

	function automatic op_code_t char_to_code(logic [7:0] c);
		op_code_t code;
		case (c)
			CH_ADD:  code = OP_ADD;
			CH_SUB:  code = OP_SUB;
			CH_MUL:  code = OP_MUL;
			CH_DIV:  code = OP_DIV;
			CH_POW:  code = OP_POW;
			default: code = OP_LPAREN;
		endcase
		return code;
	endfunction

	function automatic logic [1:0] op_prec(op_code_t code);
		logic [1:0] p;
		case (code)
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			OP_POW:         p = 2'd3;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] code_to_char(op_code_t code);
		logic [7:0] c;
		case (code)
			OP_ADD:  c = CH_ADD;
			OP_SUB:  c = CH_SUB;
			OP_MUL:  c = CH_MUL;
			OP_DIV:  c = CH_DIV;
			OP_POW:  c = CH_POW;
			default: c = CH_LPAREN;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting yard). Characters of an infix expression
// come in one item at a time on s_*; the postfix form leaves on m_*. Letters and
// digits pass through, operators go over a stack held in a synchronous RAM of
// STACK_DEPTH entries (precedence ^ over * / over + -, all left-associative),
// and s_tlast on the final character flushes the stack; the final result of an
// expression carries m_tlast, and a bare marker (m_tuser low, char 0) is sent if
// that expression step gave nothing else. Other characters are dropped. An
// unmatched ')' or a push onto a full stack sets a sticky error bit, cleared only
// by reset. Sequence: an item is taken in ST_IDLE and decoded in ST_EXEC in the
// next cycle; an operator then pops each stacked operator of equal or higher
// precedence, one RAM pop per cycle while the output is free, and is pushed; a
// ')' pops the operators above its '(' and then the '(' itself. With s_tlast the
// flush pops every stacked entry, sending operators and dropping '(', and a bare
// marker follows if needed; output back-pressure stalls each emitting step.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	input  logic        s_tlast,   // end_of_expr
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // char_out[7:0], error[8], zero[15:9]
	output logic        m_tuser,   // has_char
	output logic        m_tlast    // last_of_expr
);

	import i2p_pkg::*;

	logic [7:0] char_q;
	logic       end_q;
	logic       err_q;
	logic       out_free;
	logic       err_set;
	stk_cmd_t   cmd;
	stk_stat_t  stat;
	emit_t      emit;
	logic       m_tvalid_q;
	logic [7:0] out_char_q;
	logic       out_err_q;
	logic       out_has_q;
	logic       out_last_q;

	assign out_free = !m_tvalid_q || m_tready;

	i2p_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.char_q  (char_q),
		.end_q   (end_q),
		.out_free(out_free),
		.stat    (stat),
		.in_ready(s_tready),
		.cmd     (cmd),
		.emit    (emit),
		.err_set (err_set)
	);

	i2p_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat)
	);

	// input item capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_q <= s_tdata;
			end_q  <= s_tlast;
		end
	end

	// sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (err_set) begin
			err_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_char_q <= emit.data;
			out_err_q  <= err_q;
			out_has_q  <= emit.has_char;
			out_last_q <= emit.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, out_err_q, out_char_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/i2p_ram.sv
module i2p_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/i2p_stack.sv
module i2p_stack #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  i2p_pkg::stk_cmd_t cmd,
	output i2p_pkg::stk_stat_t stat
);

	import i2p_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] ops_q;
	logic [CW-1:0] paren_q;
	op_code_t      top_q;
	logic          top_sel_q;
	logic [2:0]    rd_data;
	logic [AW-1:0] rd_addr;
	op_code_t      top;

	// the entry below the top is fetched while the top is popped
	assign rd_addr = AW'(count_q - CW'(2));
	assign top     = top_sel_q ? op_code_t'(rd_data) : top_q;

	i2p_ram #(
		.WIDTH(3),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.push),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(cmd.code),
		.rd_en  (cmd.pop),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// depth and per-kind counts, cached top of stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ops_q     <= '0;
			paren_q   <= '0;
			top_sel_q <= 1'b0;
		end else if (cmd.push) begin
			count_q   <= count_q + CW'(1);
			top_sel_q <= 1'b0;
			if (cmd.code == OP_LPAREN) begin
				paren_q <= paren_q + CW'(1);
			end else begin
				ops_q <= ops_q + CW'(1);
			end
		end else if (cmd.pop) begin
			count_q   <= count_q - CW'(1);
			top_sel_q <= 1'b1;
			if (top == OP_LPAREN) begin
				paren_q <= paren_q - CW'(1);
			end else begin
				ops_q <= ops_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.code;
		end
	end

	// status
	always_comb begin
		stat.empty      = (count_q == '0);
		stat.full       = (count_q == CW'(DEPTH));
		stat.ops_zero   = (ops_q == '0);
		stat.ops_one    = (ops_q == CW'(1));
		stat.paren_zero = (paren_q == '0);
		stat.top        = top;
	end

endmodule

// File: rtl/i2p_ctrl.sv
module i2p_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         char_q,
	input  logic               end_q,
	input  logic               out_free,
	input  i2p_pkg::stk_stat_t stat,
	output logic               in_ready,
	output i2p_pkg::stk_cmd_t  cmd,
	output i2p_pkg::emit_t     emit,
	output logic               err_set
);

	import i2p_pkg::*;

	state_t    state_q;
	state_t    state_d;
	state_t    after_item;
	char_cls_t cls;
	op_code_t  code;
	logic      pop_op_ok;
	logic      emitted_q;

	assign cls        = classify(char_q);
	assign code       = char_to_code(char_q);
	assign pop_op_ok  = !stat.empty && (op_prec(stat.top) >= op_prec(code));
	assign after_item = end_q ? ST_FLUSH : ST_IDLE;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cls)
					CLS_OPERAND: begin
						if (out_free) begin
							state_d = after_item;
						end
					end
					CLS_CLOSE: state_d = ST_POP_CLOSE;
					CLS_OPER:  state_d = ST_POP_OP;
					default:   state_d = after_item;
				endcase
			end
			ST_POP_OP: begin
				if (!pop_op_ok) begin
					state_d = after_item;
				end
			end
			ST_POP_CLOSE: begin
				if (stat.empty || stat.top == OP_LPAREN) begin
					state_d = after_item;
				end
			end
			ST_FLUSH: begin
				if (stat.empty) begin
					state_d = emitted_q ? ST_IDLE : ST_BARE;
				end
			end
			ST_BARE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// actions per state
	always_comb begin
		in_ready      = 1'b0;
		cmd.push      = 1'b0;
		cmd.pop       = 1'b0;
		cmd.code      = code;
		emit.valid    = 1'b0;
		emit.data     = code_to_char(stat.top);
		emit.has_char = 1'b1;
		emit.last     = 1'b0;
		err_set       = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: begin
				case (cls)
					CLS_OPERAND: begin
						emit.valid = out_free;
						emit.data  = char_q;
						emit.last  = end_q && stat.ops_zero;
					end
					CLS_OPEN: begin
						cmd.code = OP_LPAREN;
						cmd.push = !stat.full;
						err_set  = stat.full;
					end
					CLS_CLOSE: err_set = stat.paren_zero;
					CLS_OPER:  err_set = stat.full && !pop_op_ok;
					default: begin
					end
				endcase
			end
			ST_POP_OP: begin
				if (pop_op_ok) begin
					emit.valid = out_free;
					cmd.pop    = out_free;
				end else begin
					cmd.push = !stat.full;
				end
			end
			ST_POP_CLOSE: begin
				if (!stat.empty) begin
					if (stat.top == OP_LPAREN) begin
						cmd.pop = 1'b1;
					end else begin
						emit.valid = out_free;
						emit.last  = end_q && stat.ops_one;
						cmd.pop    = out_free;
					end
				end
			end
			ST_FLUSH: begin
				if (!stat.empty) begin
					if (stat.top == OP_LPAREN) begin
						cmd.pop = 1'b1;
					end else begin
						emit.valid = out_free;
						emit.last  = stat.ops_one;
						cmd.pop    = out_free;
					end
				end
			end
			ST_BARE: begin
				emit.valid    = out_free;
				emit.data     = CH_NONE;
				emit.has_char = 1'b0;
				emit.last     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state and per-item emitted flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			emitted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_ready && in_valid) begin
				emitted_q <= 1'b0;
			end else if (emit.valid) begin
				emitted_q <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/i2p_checker.sv
module i2p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	logic err_seen_q;

	// error bit seen on any delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[8]) begin
			err_seen_q <= 1'b1;
		end
	end

	// a result item stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result item dropped or changed while stalled");

	// error bit never falls once reported
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_seen_q |-> m_tdata[8])
		else $error("error flag cleared after being reported");

	// a bare marker is always the end of an expression with a zero character
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
		else $error("bare marker without end flag or with a character");

	// nothing offered out of reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] == 7'd0)
		else $error("nonzero padding in result item");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import i2p_pkg::*;

	localparam int STACK_DEPTH = 16;

	// one postfix result item as seen on the output stream
	typedef struct {
		logic [7:0] ch;
		bit         has_char;
		bit         last;
		bit         err;
	} postfix_char_t;

	// shunting-yard predictor plus the queue of postfix items still owed
	class postfix_scoreboard;
		op_code_t      op_stack[STACK_DEPTH];
		int unsigned   stack_used;
		bit            err_sticky;
		postfix_char_t expected_chars[$];
		int            mismatches;
		int            checked;
		int            seen_err_set;
		int            seen_err_clear;

		function new();
			stack_used = 0;
			err_sticky = 1'b0;
			mismatches = 0;
			checked = 0;
			seen_err_set = 0;
			seen_err_clear = 0;
		endfunction

		function int prec_of(op_code_t code);
			int p;
			case (code)
				OP_ADD, OP_SUB: p = 1;
				OP_MUL, OP_DIV: p = 2;
				OP_POW:         p = 3;
				default:        p = 0;
			endcase
			return p;
		endfunction

		function logic [7:0] symbol_of(op_code_t code);
			logic [7:0] s;
			case (code)
				OP_ADD:  s = CH_ADD;
				OP_SUB:  s = CH_SUB;
				OP_MUL:  s = CH_MUL;
				OP_DIV:  s = CH_DIV;
				OP_POW:  s = CH_POW;
				default: s = CH_LPAREN;
			endcase
			return s;
		endfunction

		function bit is_operand(logic [7:0] c);
			return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
				(c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
				(c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
		endfunction

		// works out the postfix items caused by one accepted input item
		function void note_char(logic [7:0] c, bit end_flag);
			postfix_char_t step_out[$];
			postfix_char_t pc;
			op_code_t      code;
			op_code_t      t;
			bit            is_op;
			bit            found;
			is_op = 1'b1;
			code = OP_ADD;
			case (c)
				CH_ADD:  code = OP_ADD;
				CH_SUB:  code = OP_SUB;
				CH_MUL:  code = OP_MUL;
				CH_DIV:  code = OP_DIV;
				CH_POW:  code = OP_POW;
				default: is_op = 1'b0;
			endcase
			pc.last = 1'b0;
			pc.err = 1'b0;
			pc.has_char = 1'b1;
			if (is_operand(c)) begin
				pc.ch = c;
				step_out.push_back(pc);
			end else if (c == CH_RPAREN) begin
				// pop down to the matching open paren
				found = 1'b0;
				while (stack_used > 0) begin
					t = op_stack[stack_used - 1];
					stack_used--;
					if (t == OP_LPAREN) begin
						found = 1'b1;
						break;
					end
					pc.ch = symbol_of(t);
					step_out.push_back(pc);
				end
				if (!found)
					err_sticky = 1'b1;
			end else if (c == CH_LPAREN) begin
				if (stack_used < STACK_DEPTH) begin
					op_stack[stack_used] = OP_LPAREN;
					stack_used++;
				end else begin
					err_sticky = 1'b1;
				end
			end else if (is_op) begin
				// left-associative: pop equal or higher precedence first
				while (stack_used > 0 && prec_of(op_stack[stack_used - 1]) >= prec_of(code)) begin
					pc.ch = symbol_of(op_stack[stack_used - 1]);
					step_out.push_back(pc);
					stack_used--;
				end
				if (stack_used < STACK_DEPTH) begin
					op_stack[stack_used] = code;
					stack_used++;
				end else begin
					err_sticky = 1'b1;
				end
			end
			// end of expression flushes the stack, open parens dropped
			if (end_flag) begin
				while (stack_used > 0) begin
					t = op_stack[stack_used - 1];
					stack_used--;
					if (t != OP_LPAREN) begin
						pc.ch = symbol_of(t);
						step_out.push_back(pc);
					end
				end
				if (step_out.size() == 0) begin
					pc.ch = CH_NONE;
					pc.has_char = 1'b0;
					step_out.push_back(pc);
				end
				step_out[step_out.size() - 1].last = 1'b1;
			end
			foreach (step_out[i]) begin
				step_out[i].err = err_sticky;
				expected_chars.push_back(step_out[i]);
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		// compares one output item against the oldest one owed
		task check_char(logic [7:0] ch, logic has_char, logic last, logic err, logic [6:0] pad);
			postfix_char_t want;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected item char %h has %b last %b err %b",
					ch, has_char, last, err));
			end else begin
				want = expected_chars.pop_front();
				checked++;
				if (err)
					seen_err_set++;
				else
					seen_err_clear++;
				if (ch !== want.ch || has_char !== want.has_char || last !== want.last ||
					err !== want.err || pad !== 7'd0) begin
					report_mismatch($sformatf(
						"got char %h has %b last %b err %b pad %h, want %h %b %b %b",
						ch, has_char, last, err, pad, want.ch, want.has_char, want.last,
						want.err));
				end
			end
		endtask

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	postfix_scoreboard sb = new();

	bit         no_idle = 1'b0;
	bit         hold_request = 1'b0;
	int         items_sent = 0;
	int         exprs_sent = 0;
	logic [7:0] expr_q[$];

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#1_500_000;
		$display("tb_top failed");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic bit counts_as_item(logic [7:0] c, bit end_flag);
		return end_flag || sb.is_operand(c) || c == CH_LPAREN || c == CH_RPAREN ||
			c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV || c == CH_POW;
	endfunction

	function automatic logic [7:0] rand_operand();
		logic [7:0] c;
		case ($urandom_range(0, 2))
			0:       c = CH_UPPER_A + 8'($urandom_range(0, 25));
			1:       c = CH_LOWER_A + 8'($urandom_range(0, 25));
			default: c = CH_DIGIT_0 + 8'($urandom_range(0, 9));
		endcase
		return c;
	endfunction

	function automatic logic [7:0] rand_operator();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0:       c = CH_ADD;
			1:       c = CH_SUB;
			2:       c = CH_MUL;
			3:       c = CH_DIV;
			default: c = CH_POW;
		endcase
		return c;
	endfunction

	// any byte the block drops
	function automatic logic [7:0] rand_junk();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (counts_as_item(c, 1'b0));
		return c;
	endfunction

	// offer one item and wait for it to be taken
	task automatic send_char(logic [7:0] c, bit end_flag);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= end_flag;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_char(c, end_flag);
		if (counts_as_item(c, end_flag))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic send_string(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
		exprs_sent++;
	endtask

	task automatic send_expr_q();
		foreach (expr_q[i])
			send_char(expr_q[i], i == expr_q.size() - 1);
		exprs_sent++;
	endtask

	// random well-formed expression, nesting kept shallow enough for the stack
	task automatic build_expression();
		int terms;
		int opens;
		terms = $urandom_range(1, 7);
		opens = 0;
		expr_q.delete();
		for (int t = 0; t < terms; t++) begin
			if (opens < 3 && $urandom_range(0, 3) == 0) begin
				expr_q.push_back(CH_LPAREN);
				opens++;
			end
			expr_q.push_back(rand_operand());
			if (opens > 0 && $urandom_range(0, 2) == 0) begin
				expr_q.push_back(CH_RPAREN);
				opens--;
			end
			if ($urandom_range(0, 19) == 0)
				expr_q.push_back(rand_junk());
			if (t < terms - 1)
				expr_q.push_back(rand_operator());
		end
		// now and then leave open parens for the flush to drop
		if ($urandom_range(0, 9) != 0) begin
			while (opens > 0) begin
				expr_q.push_back(CH_RPAREN);
				opens--;
			end
		end
	endtask

	// noise: raw bytes mixed with stray parens and operators
	function automatic logic [7:0] rand_noise();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0, 1:    c = 8'($urandom_range(0, 255));
			2:       c = ($urandom_range(0, 1) == 0) ? CH_LPAREN : CH_RPAREN;
			3:       c = rand_operator();
			default: c = rand_operand();
		endcase
		return c;
	endfunction

	// receiver ready: random stalls plus one long hold on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_char(m_tdata[7:0], m_tuser, m_tlast, m_tdata[8], m_tdata[15:9]);
	end

	// main sequence
	initial begin
		int waited;
		int noise_target;
		bit end_flag;
		logic [7:0] c;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: all operators and precedence levels, a parenthesised group
		send_string("A+b*C^D-(Z/z)");
		// digit extremes, dropped bytes at both ends of the range, end on a dropped byte
		send_char(8'h00, 1'b0);
		send_char(CH_DIGIT_0, 1'b0);
		send_char(CH_MUL, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_DIGIT_9, 1'b0);
		send_char("#", 1'b1);
		exprs_sent++;
		// bare end markers: lone open paren, lone dropped byte
		send_string("(");
		send_string(" ");
		send_string("a");

		// random well-formed expressions, the first ones back to back under a long hold
		no_idle = 1'b1;
		hold_request = 1'b1;
		while (items_sent < 95) begin
			if (items_sent > 60)
				no_idle = 1'b0;
			build_expression();
			send_expr_q();
		end

		// noise and broken sequences
		noise_target = items_sent + 25;
		while (items_sent < noise_target) begin
			c = rand_noise();
			end_flag = ($urandom_range(0, 5) == 0);
			send_char(c, end_flag);
			if (end_flag)
				exprs_sent++;
		end
		send_char(CH_DIGIT_0, 1'b1);

		// unmatched close, then stack overflow on both paren and operator
		send_string("x+y)");
		for (int i = 0; i < STACK_DEPTH + 1; i++)
			send_char(CH_LPAREN, 1'b0);
		send_char(CH_MUL, 1'b0);
		send_char("q", 1'b1);
		exprs_sent++;
		send_string("m-n");

		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		// drain
		waited = 0;
		while (sb.pending() > 0 && waited < 200_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		while (sb.pending() > 0) begin
			sb.report_mismatch($sformatf("postfix item char %h never arrived",
				sb.expected_chars[0].ch));
			void'(sb.expected_chars.pop_front());
		end

		$display("run covered %0d input items over %0d expressions, %0d output items checked",
			items_sent, exprs_sent, sb.checked);
		$display("error flag low on %0d output items, high on %0d; %0d mismatches",
			sb.seen_err_clear, sb.seen_err_set, sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// File: files.f
rtl/i2p_pkg.sv
rtl/i2p_ram.sv
rtl/i2p_stack.sv
rtl/i2p_ctrl.sv
rtl/infix_to_postfix_converter.sv
rtl/i2p_checker.sv
test/tb_top.sv
